FILE: hdl/apvq_pkg.sv
// ----------------------------------------------------------------------------
// apvq_pkg
// Shared types, status codes and key helpers of the magnitude-ordered queue.
// ----------------------------------------------------------------------------
package apvq_pkg;

    localparam int VALUE_W  = 32;
    localparam int KEY_W    = VALUE_W + 1;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // key: magnitude above, low bit 0 for negative so it sorts first
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_cell_link;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

    function automatic logic [KEY_W-1:0] value_to_key(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
        return {mag, ~value[VALUE_W-1]};
    endfunction

    function automatic logic [VALUE_W-1:0] key_to_value(input logic [KEY_W-1:0] key);
        logic [VALUE_W-1:0] mag;
        mag = key[KEY_W-1:1];
        return key[0] ? mag : (~mag + VALUE_W'(1));
    endfunction

endpackage

FILE: hdl/apvq_cell.sv
// ----------------------------------------------------------------------------
// apvq_cell
// One slot of the sorted chain: takes new key, left key, right key or keeps.
// ----------------------------------------------------------------------------
module apvq_cell
    import apvq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [KEY_W-1:0] i_new_key,
    input  t_cell_link       i_left,
    input  logic             i_left_lt,
    input  t_cell_link       i_right,
    output t_cell_link       o_own,
    output logic             o_lt
);

    t_cell_link r_own;
    t_cell_link n_own;

    // new key sorts before this slot (an empty slot counts as infinite)
    assign o_lt  = !r_own.valid || (i_new_key < r_own.key);
    assign o_own = r_own;

    always_comb begin
        n_own = r_own;
        if (i_ctrl.pop) begin
            n_own = i_right;
        end else if (i_ctrl.insert && o_lt) begin
            if (i_left_lt) begin
                n_own = i_left;
            end else begin
                n_own.valid = 1'b1;
                n_own.key   = i_new_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own.valid <= 1'b0;
        end else begin
            r_own.valid <= n_own.valid;
        end
        r_own.key <= n_own.key;
    end

endmodule

FILE: hdl/absolute_value_priority_queue.sv
// ----------------------------------------------------------------------------
// absolute_value_priority_queue
// Priority queue keyed by magnitude, negative first on equal magnitude.
// ----------------------------------------------------------------------------
// Usage: each transaction on the s_axis side carries one signed value. A
// nonzero value is inserted; zero pops the entry of smallest magnitude.
// Every input transaction yields exactly one m_axis transaction: tdata holds
// the popped value (0 otherwise), tuser the status (inserted, popped, popped
// empty, insert dropped because full).
// Storage is a row of CAPACITY cells kept sorted, smallest at cell 0. An
// insert lets every cell compare the new key with its own in parallel and
// shift right where needed; a pop shifts every cell left by one.
// Throughput is one item per cycle while s_axis_tready is high, set by the
// combinational compare-and-shift over the cell row.
// The result sits in an output register; a new item is taken while that
// register is empty or being drained. A stalled receiver holds s_axis_tready
// low once the register is full.
// Reset empties the queue (all cell valid bits cleared).
// ----------------------------------------------------------------------------
module absolute_value_priority_queue
    import apvq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] item_value
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [VALUE_W-1:0]  m_axis_tdata,   // [31:0] result_value
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_data;
    t_status             r_out_status;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [VALUE_W-1:0]  n_out_data;
    t_status             n_out_status;

    logic                w_accept;
    logic                w_is_pop;
    logic                w_full;
    logic                w_empty;
    logic [KEY_W-1:0]    w_new_key;
    t_cell_ctrl          w_ctrl;
    t_cell_link          w_own [CAPACITY];
    logic                w_lt  [CAPACITY];

    localparam t_cell_link EMPTY_LINK = '{valid: 1'b0, key: '0};

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_pop      = (s_axis_tdata == '0);
    assign w_full        = (r_count == COUNT_W'(CAPACITY));
    assign w_empty       = (r_count == '0);
    assign w_new_key     = value_to_key(s_axis_tdata);

    assign w_ctrl.insert = w_accept && !w_is_pop && !w_full;
    assign w_ctrl.pop    = w_accept && w_is_pop && !w_empty;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;
        logic       w_left_lt;

        if (i == 0) begin : g_first
            assign w_left    = EMPTY_LINK;
            assign w_left_lt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_own[i-1];
            assign w_left_lt = w_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right = EMPTY_LINK;
        end else begin : g_inner
            assign w_right = w_own[i+1];
        end

        apvq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_new_key (w_new_key),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_own     (w_own[i]),
            .o_lt      (w_lt[i])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_data   = '0;
        n_out_status = ST_INSERTED;
        if (w_is_pop) begin
            if (w_empty) begin
                n_out_status = ST_EMPTY;
            end else begin
                n_out_status = ST_POPPED;
                n_out_data   = key_to_value(w_own[0].key);
                n_count      = r_count - COUNT_W'(1);
            end
        end else begin
            if (w_full) begin
                n_out_status = ST_FULL;
            end else begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: tb/absolute_value_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// absolute_value_priority_queue_tb
// Self-checking bench for the magnitude-ordered priority queue.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own unordered copy of the queue contents and works
// out the expected value and status for every accepted input transaction:
// insert, pop of the smallest magnitude (negative first on a tie), pop from
// empty, and insert dropped when full. Directed extremes come first, then
// random traffic that fills the queue to capacity and drains it partly.
// Both sides idle at random, and the receiver stalls for a long stretch once
// so that the block backs up into its input.
// ----------------------------------------------------------------------------
module absolute_value_priority_queue_tb
    import apvq_pkg::*;
();

    localparam int QUEUE_DEPTH  = 1024;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRESSURE_AT  = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_outcome;

    class queue_scoreboard;
        logic [VALUE_W-1:0] held[$];
        t_outcome           awaited[$];
        int                 capacity;
        int                 errors;
        int                 results_seen;

        function new(int depth);
            capacity     = depth;
            errors       = 0;
            results_seen = 0;
        endfunction

        // magnitude above, low bit clear for negative
        function logic [VALUE_W:0] order_key(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
            return {mag, !v[VALUE_W-1]};
        endfunction

        function void note_input(logic [VALUE_W-1:0] v);
            t_outcome         o;
            int               best;
            logic [VALUE_W:0] best_key;
            o.value = '0;
            if (v != '0) begin
                if (held.size() >= capacity) begin
                    o.status = ST_FULL;
                end else begin
                    held.push_back(v);
                    o.status = ST_INSERTED;
                end
            end else if (held.size() == 0) begin
                o.status = ST_EMPTY;
            end else begin
                best     = 0;
                best_key = order_key(held[0]);
                for (int i = 1; i < held.size(); i++) begin
                    if (order_key(held[i]) < best_key) begin
                        best_key = order_key(held[i]);
                        best     = i;
                    end
                end
                o.value  = held[best];
                o.status = ST_POPPED;
                held.delete(best);
            end
            awaited.push_back(o);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [VALUE_W-1:0] data, logic [STATUS_W-1:0] status);
            t_outcome o;
            results_seen++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding (value %h)",
                                 results_seen, data));
            end else begin
                o = awaited.pop_front();
                if (data !== o.value)
                    report($sformatf("result %0d value %h, expected %h",
                                     results_seen, data, o.value));
                if (status !== o.status)
                    report($sformatf("result %0d status %0d, expected %s",
                                     results_seen, status, o.status.name()));
            end
        endtask
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata   = '0;      // [31:0] item_value
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [VALUE_W-1:0]  m_axis_tdata;             // [31:0] result_value
    logic [STATUS_W-1:0] m_axis_tuser;             // [1:0] status

    queue_scoreboard sb = new(QUEUE_DEPTH);
    bit              send_burst = 1'b0;
    bit              recv_burst = 1'b1;
    int              idle_cycles;

    absolute_value_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // zero_pct: chance in percent of a pop request
    function automatic logic [VALUE_W-1:0] pick_value(int zero_pct);
        logic [VALUE_W-1:0] v;
        int                 r;
        int                 s;
        if ($urandom_range(0, 99) < zero_pct)
            return '0;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            s = $urandom_range(1, 6);
            v = $urandom_range(0, 1) ? -s : s;
        end else if (r < 45) begin
            case ($urandom_range(0, 4))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h8000_0001;
                3: v = 32'h0000_0001;
                default: v = 32'hffff_ffff;
            endcase
        end else begin
            v = $urandom();
            if (v == '0)
                v = 32'h1;
        end
        return v;
    endfunction

    task automatic offer_value(logic [VALUE_W-1:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(v);
    endtask

    // receiver
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sb.results_seen == PRESSURE_AT)
                gap = HOLD_CYCLES;
            else
                gap = recv_burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [VALUE_W-1:0] directed[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pop on empty, extremes, ties on magnitude, duplicates, then drain
        directed = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h1,
                     32'hffff_ffff, 32'h5, 32'hffff_fffb, 32'h5, 32'hffff_fffb,
                     32'h7fff_ffff};
        foreach (directed[i])
            offer_value(directed[i]);
        repeat (11) offer_value('0);

        repeat (200) offer_value(pick_value(45));

        // fill to capacity, then hit the full case
        while (sb.held.size() < QUEUE_DEPTH)
            offer_value(pick_value(8));
        offer_value(32'h8000_0000);
        repeat (12) offer_value(pick_value(15));

        repeat (150) offer_value(pick_value(50));
        s_axis_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/apvq_pkg.sv
hdl/apvq_cell.sv
hdl/absolute_value_priority_queue.sv
tb/absolute_value_priority_queue_tb.sv
